FILE: rtl/msb_pkg.sv
// Shared types and constants for the merge sort buffer.
// Has no dependencies; merge_sort_buffer.sv uses it by scoped names.
package msb_pkg;

  // Width of one stored element.
  localparam int unsigned DATA_W = 32;

  // One signed element as it travels through the buffer.
  typedef logic signed [DATA_W-1:0] data_t;

endpackage : msb_pkg

FILE: rtl/merge_sort_buffer.sv
// Merge sort buffer: collects a run of signed words and returns them in ascending order.
// Depends on msb_pkg for the element type.
//
// Input words are accepted while the run is being collected. The word flagged is_last
// closes the run. The block then sorts the run bottom-up and drops in_stall again
// only once the whole sorted run has been delivered. A single comparator works from
// a two-bank buffer memory with one read port and one write port. Each merge step
// moves one word per cycle, and every merged segment first primes its heads in S_SEG
// and S_PRIME. Output then follows at one word per cycle, after S_OUT_RD and S_OUT_FIRST,
// when the receiver does not stall. Words that arrive once the store holds MAX_ITEMS
// are dropped, and every result of that run has out_overflowed set.
module merge_sort_buffer #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  // Input channel
  input  logic           in_valid,
  output logic           in_stall,
  input  msb_pkg::data_t in_value,
  input  logic           in_is_last,
  // Result channel
  output logic           out_valid,
  input  logic           out_stall,
  output msb_pkg::data_t out_sorted_value,
  output logic           out_end_of_run,
  output logic           out_overflowed
);

  // Index width within a bank, count width (holds MAX_ITEMS itself) and sum width.
  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW = CW + 2;
  localparam int unsigned MEM_DEPTH = 2 ** (AW + 1);

  typedef enum logic [2:0] {
    S_COLLECT,
    S_SEG,
    S_PRIME,
    S_MERGE,
    S_OUT_RD,
    S_OUT_FIRST,
    S_OUT
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           dropped_r, dropped_nxt;
  logic [CW-1:0]  width_r, width_nxt;
  logic [CW-1:0]  lo_r, lo_nxt;
  logic [CW-1:0]  mid_r, mid_nxt;
  logic [CW-1:0]  hi_r, hi_nxt;
  logic [CW-1:0]  a_r, a_nxt;
  logic [CW-1:0]  b_r, b_nxt;
  logic [CW-1:0]  k_r, k_nxt;
  logic           bank_r, bank_nxt;
  msb_pkg::data_t head_a_r, head_a_nxt;
  msb_pkg::data_t head_b_r, head_b_nxt;
  logic           fresh_a_r, fresh_a_nxt;
  logic [CW-1:0]  out_idx_r, out_idx_nxt;
  logic           out_valid_r, out_valid_nxt;
  msb_pkg::data_t out_value_r, out_value_nxt;
  logic           out_end_r, out_end_nxt;

  // Buffer memory: two banks of 2**AW words (at least MAX_ITEMS each), selected by the top address bit.
  msb_pkg::data_t mem [MEM_DEPTH];
  msb_pkg::data_t rd_data_r;
  logic           rd_en;
  logic [AW:0]    rd_addr;
  logic           wr_en;
  logic [AW:0]    wr_addr;
  msb_pkg::data_t wr_data;

  // Handshake terms.
  logic in_acc;
  logic out_acc;

  // Segment bounds and merge decision.
  logic [SW-1:0]  n_w;
  logic [SW-1:0]  seg_mid_w;
  logic [SW-1:0]  seg_hi_w;
  logic [SW-1:0]  width2_w;
  logic [CW-1:0]  mid_c;
  logic [CW-1:0]  hi_c;
  logic [CW-1:0]  count_inc;
  logic [CW-1:0]  a_inc;
  logic [CW-1:0]  b_inc;
  logic [CW-1:0]  k_inc;
  logic [CW-1:0]  out_inc;
  msb_pkg::data_t head_a;
  msb_pkg::data_t head_b;
  logic           a_ok;
  logic           b_ok;
  logic           take_a;

  assign in_acc  = in_valid && (state_r == S_COLLECT);
  assign out_acc = out_valid_r && !out_stall;

  assign in_stall         = (state_r != S_COLLECT);
  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_end_of_run   = out_end_r;
  assign out_overflowed   = dropped_r;

  // Segment bounds for the current width, clamped to the run length.
  assign n_w       = SW'(count_r);
  assign width2_w  = SW'({width_r, 1'b0});
  assign seg_mid_w = SW'(lo_r) + SW'(width_r);
  assign seg_hi_w  = SW'(lo_r) + width2_w;
  assign mid_c     = (seg_mid_w > n_w) ? count_r : seg_mid_w[CW-1:0];
  assign hi_c      = (seg_hi_w > n_w) ? count_r : seg_hi_w[CW-1:0];

  assign count_inc = count_r + CW'(1);
  assign a_inc     = a_r + CW'(1);
  assign b_inc     = b_r + CW'(1);
  assign k_inc     = k_r + CW'(1);
  assign out_inc   = out_idx_r + CW'(1);

  // The head just fetched sits in the read register; the other head is held.
  assign head_a = fresh_a_r ? rd_data_r : head_a_r;
  assign head_b = fresh_a_r ? head_b_r : rd_data_r;
  assign a_ok   = (a_r < mid_r);
  assign b_ok   = (b_r < hi_r);
  assign take_a = a_ok && (!b_ok || (head_a < head_b));

  // Sequencer: collection, merge passes and delivery.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    width_nxt     = width_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    k_nxt         = k_r;
    bank_nxt      = bank_r;
    head_a_nxt    = head_a_r;
    head_b_nxt    = head_b_r;
    fresh_a_nxt   = fresh_a_r;
    out_idx_nxt   = out_idx_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_end_nxt   = out_end_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = {1'b0, count_r[AW-1:0]};
    wr_data       = in_value;

    case (state_r)
      S_COLLECT: begin
        if (in_acc) begin
          if (count_r < CW'(MAX_ITEMS)) begin
            wr_en     = 1'b1;
            count_nxt = count_inc;
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_is_last) begin
            bank_nxt    = 1'b0;
            lo_nxt      = '0;
            width_nxt   = CW'(1);
            out_idx_nxt = '0;
            // A run of one word is already in order.
            if (count_nxt > CW'(1)) begin
              state_nxt = S_SEG;
            end else begin
              state_nxt = S_OUT_RD;
            end
          end
        end
      end

      S_SEG: begin
        // Open a segment and fetch the head of its left half.
        mid_nxt   = mid_c;
        hi_nxt    = hi_c;
        a_nxt     = lo_r;
        b_nxt     = mid_c;
        k_nxt     = lo_r;
        rd_en     = 1'b1;
        rd_addr   = {bank_r, lo_r[AW-1:0]};
        state_nxt = S_PRIME;
      end

      S_PRIME: begin
        // Hold the left head and fetch the head of the right half.
        head_a_nxt  = rd_data_r;
        fresh_a_nxt = 1'b0;
        rd_en       = 1'b1;
        rd_addr     = {bank_r, b_r[AW-1:0]};
        state_nxt   = S_MERGE;
      end

      S_MERGE: begin
        // Move the smaller head to the other bank and fetch its successor.
        wr_en   = 1'b1;
        wr_addr = {~bank_r, k_r[AW-1:0]};
        rd_en   = 1'b1;
        k_nxt   = k_inc;
        if (take_a) begin
          wr_data     = head_a;
          a_nxt       = a_inc;
          rd_addr     = {bank_r, a_inc[AW-1:0]};
          fresh_a_nxt = 1'b1;
          head_b_nxt  = head_b;
        end else begin
          wr_data     = head_b;
          b_nxt       = b_inc;
          rd_addr     = {bank_r, b_inc[AW-1:0]};
          fresh_a_nxt = 1'b0;
          head_a_nxt  = head_a;
        end
        if (k_inc == hi_r) begin
          if (seg_hi_w >= n_w) begin
            // Pass complete: the merged run now lives in the other bank.
            bank_nxt = ~bank_r;
            lo_nxt   = '0;
            if (width2_w >= n_w) begin
              out_idx_nxt = '0;
              state_nxt   = S_OUT_RD;
            end else begin
              width_nxt = width2_w[CW-1:0];
              state_nxt = S_SEG;
            end
          end else begin
            lo_nxt    = seg_hi_w[CW-1:0];
            state_nxt = S_SEG;
          end
        end
      end

      S_OUT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = {bank_r, out_idx_r[AW-1:0]};
        state_nxt = S_OUT_FIRST;
      end

      S_OUT_FIRST: begin
        // Present the first word and prefetch the next one.
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_data_r;
        out_end_nxt   = (out_inc == count_r);
        rd_en         = 1'b1;
        rd_addr       = {bank_r, out_inc[AW-1:0]};
        out_idx_nxt   = out_inc;
        state_nxt     = S_OUT;
      end

      S_OUT: begin
        if (out_acc) begin
          if (out_end_r) begin
            // Run delivered: clear the run state and take input again.
            out_valid_nxt = 1'b0;
            out_end_nxt   = 1'b0;
            count_nxt     = '0;
            dropped_nxt   = 1'b0;
            state_nxt     = S_COLLECT;
          end else begin
            out_value_nxt = rd_data_r;
            out_end_nxt   = (out_inc == count_r);
            rd_en         = 1'b1;
            rd_addr       = {bank_r, out_inc[AW-1:0]};
            out_idx_nxt   = out_inc;
          end
        end
      end

      default: begin
        state_nxt = S_COLLECT;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_COLLECT;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_end_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
      out_end_r   <= out_end_nxt;
    end
    width_r     <= width_nxt;
    lo_r        <= lo_nxt;
    mid_r       <= mid_nxt;
    hi_r        <= hi_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    k_r         <= k_nxt;
    bank_r      <= bank_nxt;
    head_a_r    <= head_a_nxt;
    head_b_r    <= head_b_nxt;
    fresh_a_r   <= fresh_a_nxt;
    out_idx_r   <= out_idx_nxt;
    out_value_r <= out_value_nxt;
  end

  // Buffer memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

`ifndef SYNTH
  // Input is never taken while a sorted word is on offer.
  a_no_input_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while results pending");

  // The run never holds more words than the store.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("element count beyond capacity");

  // Every word written during a merge comes from exactly one of the two halves.
  a_merge_balance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MERGE) |->
      ((SW'(k_r) + SW'(mid_r)) == (SW'(a_r) + SW'(b_r))))
    else $error("merge indices out of step");

  // Delivering the final word returns the block to collection.
  a_run_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_end_of_run) |=> (!out_valid && !in_stall))
    else $error("block did not reopen after end of run");
`endif

endmodule : merge_sort_buffer
